>>> sv/pbav_pkg.sv
// ----------------------------------------------------------------------------
// pbav_pkg: shared types and constants for the 2x2 pixel binning core
// Payload structs of the request, response and register channels, register
// indexes and fixed field widths.
// ----------------------------------------------------------------------------
package pbav_pkg;

   localparam int PIXEL_WIDTH    = 16;
   localparam int SIZE_WIDTH     = 13;
   localparam int ROW_BITS       = 12;
   localparam int MAX_HEIGHT     = 4096;
   localparam int SIZE_RESET     = 2048;
   localparam int CSR_INDEX_BITS = 4;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_value;
      logic                   frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] binned_value;
      logic                   frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [SIZE_WIDTH-1:0]     wr_data;
   } csr_payload_type;

   // Result handed from the front end to the output queue.
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } front_push_type;

endpackage

>>> sv/pbav_stream_if.sv
// ----------------------------------------------------------------------------
// pbav_stream_if: valid/ready channel
// One transaction moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface pbav_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/pbav_ram.sv
// ----------------------------------------------------------------------------
// pbav_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbav_ram #(
   parameter int DATA_WIDTH = 17,
   parameter int DEPTH      = 2048
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);
   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/pbav_front.sv
// ----------------------------------------------------------------------------
// pbav_front: position tracking, line store and block averaging
// Places each pixel in the frame, keeps pair sums of even rows and
// produces one rounded block mean per completed 2x2 block.
// ----------------------------------------------------------------------------
module pbav_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  pbav_pkg::req_payload_type           pixel,
   input  logic [pbav_pkg::SIZE_WIDTH-1:0]     frame_width,
   input  logic [pbav_pkg::SIZE_WIDTH-1:0]     frame_height,
   output pbav_pkg::front_push_type            push
);
   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int WB_MIN     = $clog2(MAX_WIDTH + 1);
   localparam int WB         = (WB_MIN > pbav_pkg::SIZE_WIDTH) ? WB_MIN : pbav_pkg::SIZE_WIDTH;
   localparam int HB         = pbav_pkg::SIZE_WIDTH;
   localparam int RB         = pbav_pkg::ROW_BITS;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int AB         = $clog2(LINE_DEPTH);
   localparam int SUM_BITS   = PIXEL_BITS + 1;

   logic [CW-1:0]         col_ff, col_in;
   logic [RB-1:0]         row_ff, row_in;
   logic [PIXEL_BITS-1:0] left_ff, left_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_last_ff, s1_last_in;
   logic [SUM_BITS-1:0]   s1_pair_ff, s1_pair_in;

   logic [WB-1:0]         wid_ext, w_val, used_w, col_next;
   logic [HB-1:0]         h_val, used_h, row_step, row_next;
   logic [CW-1:0]         col_start, c_val;
   logic [RB-1:0]         row_start, r_val;
   logic [PIXEL_BITS-1:0] p_val;
   logic [SUM_BITS-1:0]   pair_sum, line_rd;
   logic [AB-1:0]         line_idx;
   logic                  in_block, line_wr;
   logic [SUM_BITS+1:0]   block_total;
   logic [PIXEL_BITS-1:0] block_mean;

   always_comb begin
      // Clamp the programmed sizes to the supported range.
      wid_ext = WB'(frame_width);
      if (wid_ext < WB'(2)) begin
         w_val = WB'(2);
      end else if (wid_ext > WB'(MAX_WIDTH)) begin
         w_val = WB'(MAX_WIDTH);
      end else begin
         w_val = wid_ext;
      end
      if (frame_height < HB'(2)) begin
         h_val = HB'(2);
      end else if (frame_height > HB'(pbav_pkg::MAX_HEIGHT)) begin
         h_val = HB'(pbav_pkg::MAX_HEIGHT);
      end else begin
         h_val = frame_height;
      end
      used_w = {w_val[WB-1:1], 1'b0};
      used_h = {h_val[HB-1:1], 1'b0};

      col_start = pixel.frame_start ? '0 : col_ff;
      row_start = pixel.frame_start ? '0 : row_ff;

      // Wrap a stale position left over from a size change.
      if (WB'(col_start) >= w_val) begin
         c_val    = '0;
         row_step = HB'(row_start) + HB'(1);
      end else begin
         c_val    = col_start;
         row_step = HB'(row_start);
      end
      r_val = (row_step >= h_val) ? '0 : RB'(row_step);

      // Advance to the next position.
      col_next = WB'(c_val) + WB'(1);
      row_next = HB'(r_val) + HB'(1);
      if (col_next >= w_val) begin
         col_in = '0;
         row_in = (row_next >= h_val) ? '0 : RB'(row_next);
      end else begin
         col_in = CW'(col_next);
         row_in = r_val;
      end

      p_val    = pixel.pixel_value[PIXEL_BITS-1:0];
      pair_sum = SUM_BITS'(left_ff) + SUM_BITS'(p_val);
      line_idx = AB'(c_val >> 1);
      in_block = (HB'(r_val) < used_h) && (WB'(c_val) < used_w);

      left_in = (accept && in_block && !c_val[0]) ? p_val : left_ff;
      line_wr = accept && in_block && c_val[0] && !r_val[0];

      s1_valid_in = accept && in_block && c_val[0] && r_val[0];
      s1_pair_in  = pair_sum;
      s1_last_in  = (HB'(r_val) == used_h - HB'(1)) && (WB'(c_val) == used_w - WB'(1));

      // Odd row: add the stored even-row pair, round half up.
      block_total = (SUM_BITS+2)'(line_rd) + (SUM_BITS+2)'(s1_pair_ff) + (SUM_BITS+2)'(2);
      block_mean  = block_total[SUM_BITS:2];
   end

   pbav_ram #(
      .DATA_WIDTH (SUM_BITS),
      .DEPTH      (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (line_idx),
      .wr_data (pair_sum),
      .rd_addr (line_idx),
      .rd_data (line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         left_ff     <= left_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_pair_ff <= s1_pair_in;
      s1_last_ff <= s1_last_in;
   end

   assign push.valid                = s1_valid_ff;
   assign push.payload.binned_value = pbav_pkg::PIXEL_WIDTH'(block_mean);
   assign push.payload.frame_last   = s1_last_ff;
endmodule

>>> sv/pbav_queue.sv
// ----------------------------------------------------------------------------
// pbav_queue: result queue
// Small FIFO that decouples block averaging from the response receiver.
// ----------------------------------------------------------------------------
module pbav_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pbav_pkg::front_push_type                push,
   input  logic                                    pop,
   output logic                                    out_valid,
   output pbav_pkg::rsp_payload_type               out_payload,
   output logic [pbav_pkg::QUEUE_CNT_BITS-1:0]     count
);
   localparam int PB = pbav_pkg::QUEUE_PTR_BITS;
   localparam int NB = pbav_pkg::QUEUE_CNT_BITS;

   pbav_pkg::rsp_payload_type slot_ff [pbav_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0] count_ff, count_in;
   logic          do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push.valid ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff + NB'(push.valid) - NB'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.payload;
      end
   end

   assign out_valid   = (count_ff != '0);
   assign out_payload = slot_ff[rd_ptr_ff];
   assign count       = count_ff;
endmodule

>>> sv/pixel_binning_2x2_average_core.sv
// ----------------------------------------------------------------------------
// pixel_binning_2x2_average_core: 2x2 box-filter downsampler
// Averages each 2x2 block of a raster-order gray frame into one pixel.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  carries one pixel per transaction (pixel_value, frame_start).
//           frame_start places the pixel at row 0, column 0.
//   rsp_if  carries one binned pixel per completed 2x2 block, with
//           frame_last set on the bottom-right block of the frame.
//   csr_if  writes frame_width (index 0) or frame_height (index 1); it is
//           always ready. Write only while no pixel is in flight.
// Throughput: one pixel per clock while req_if.ready is high. The front end
//   places the pixel, writes the even-row pair sum into the line RAM or reads
//   it back on odd rows; nothing in that path iterates.
// Path: once the pixel that completes a block is accepted, the line RAM read
//   and the pair sum are registered, then the rounded mean is written into
//   the queue, from which rsp_if presents it.
// Stall: a four-entry queue holds results while rsp_if.ready is low;
//   req_if.ready drops once the queue and the in-flight result fill it.
// Reset: clears counters, the queue and the sizes (2048 x 2048); the line
//   RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pixel_binning_2x2_average_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   pbav_stream_if.sink         req_if,
   pbav_stream_if.source       rsp_if,
   pbav_stream_if.sink         csr_if
);
   localparam int NB = pbav_pkg::QUEUE_CNT_BITS;
   localparam int SW = pbav_pkg::SIZE_WIDTH;

   logic [SW-1:0] frame_width_ff, frame_width_in;
   logic [SW-1:0] frame_height_ff, frame_height_in;
   logic          csr_write;
   logic          req_accept;
   logic [NB-1:0] queue_count;
   logic [NB:0]   occupancy;

   pbav_pkg::req_payload_type req_payload;
   pbav_pkg::csr_payload_type csr_payload;
   pbav_pkg::rsp_payload_type rsp_payload;
   pbav_pkg::front_push_type  push;
   logic                      rsp_valid;

   // Size registers: take a write whenever it arrives.
   always_comb begin
      csr_payload     = csr_if.payload;
      csr_write       = csr_if.valid;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         case (csr_payload.reg_index)
            pbav_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_payload.wr_data;
            pbav_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_payload.wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SW'(pbav_pkg::SIZE_RESET);
         frame_height_ff <= SW'(pbav_pkg::SIZE_RESET);
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   assign csr_if.ready = 1'b1;

   // Hold off new pixels when the queue could not absorb the in-flight result.
   assign occupancy     = (NB+1)'(queue_count) + (NB+1)'(push.valid);
   assign req_if.ready  = (occupancy < (NB+1)'(pbav_pkg::QUEUE_DEPTH));
   assign req_accept    = req_if.valid && req_if.ready;
   assign req_payload   = req_if.payload;

   pbav_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .pixel        (req_payload),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .push         (push)
   );

   pbav_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pop         (rsp_if.ready),
      .out_valid   (rsp_valid),
      .out_payload (rsp_payload),
      .count       (queue_count)
   );

   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_payload;
endmodule

>>> sv/pbav_checker.sv
// ----------------------------------------------------------------------------
// pbav_checker: port-level checks for the 2x2 binning core
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module pbav_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  pbav_pkg::rsp_payload_type rsp_payload
);
   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

   // No result may appear without a pixel accepted before it.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // Reset empties the result queue.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The block is ready for pixels as soon as reset ends.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready)
      else $error("request not ready after reset");
endmodule

bind pixel_binning_2x2_average_core pbav_checker u_pbav_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

>>> tb/pixel_binning_2x2_average_core_tb.sv
// ----------------------------------------------------------------------------
// pixel_binning_2x2_average_core_tb: self-checking bench for the 2x2 binner
// Streams raster-order pixels through the core, predicts every binned pixel
// in a behavioral model of the line store and counters, and compares each
// response transaction field by field. A short directed pass runs first,
// then randomized frames of many sizes.
// ----------------------------------------------------------------------------
module pixel_binning_2x2_average_core_tb;

   localparam int SW            = pbav_pkg::SIZE_WIDTH;
   localparam int FRAME_MAX     = 4096;      // widest row the core takes
   localparam int LINE_ENTRIES  = FRAME_MAX / 2;
   localparam int RANDOM_ITEMS  = 660;
   localparam int SETTLE_CYCLES = 4;         // pipeline depth plus margin
   localparam int TAIL_CYCLES   = 8;
   localparam int LONG_HOLD     = 300;       // one long back-pressure stretch
   localparam int STALL_LIMIT   = 2000;      // cycles with no transaction at all

   typedef enum logic [1:0] {ROW_PIXEL, ROW_WIDTH, ROW_HEIGHT} row_kind_type;

   // One line of the directed sequence. For pixel lines with pin set, the
   // binned pixel is typed in by hand instead of taken from the predictor.
   typedef struct {
      row_kind_type kind;
      logic [15:0]  value;       // pixel value, or frame size for register lines
      bit           fs;
      bit           pin;
      logic [15:0]  want;
      bit           want_last;
   } stim_row_type;

   logic clock;
   logic reset;

   pbav_stream_if #(.payload_type(pbav_pkg::req_payload_type)) req_if ();
   pbav_stream_if #(.payload_type(pbav_pkg::rsp_payload_type)) rsp_if ();
   pbav_stream_if #(.payload_type(pbav_pkg::csr_payload_type)) csr_if ();

   pixel_binning_2x2_average_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Predictor state: register copies, pair-sum line store, counters.
   logic [SW-1:0]         frame_width_reg;
   logic [SW-1:0]         frame_height_reg;
   logic [16:0]           pair_sum_store [LINE_ENTRIES];
   bit                    pair_sum_valid [LINE_ENTRIES];
   logic [15:0]           left_px;
   int unsigned           col_pos;
   int unsigned           row_pos;

   pbav_pkg::rsp_payload_type binned_expect_q [$];

   // Hand-typed result riding along with the pixel on the request channel;
   // driven with the payload so the monitor sees it on the same edge.
   bit                        pinned_check;
   pbav_pkg::rsp_payload_type pinned_result;

   int  fail_count;
   int  idle_cycles;
   bit  sender_quiet;
   bit  sink_quiet;
   bit  hold_off_request;

   stim_row_type directed_rows [35];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------

   task automatic flag_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Clamp a size register the way the core does: below 2 acts as 2,
   // above the top acts as the top.
   function automatic int unsigned size_limit(input logic [SW-1:0] v,
                                              input int unsigned hi);
      if (v < 2)
         return 2;
      if (v > hi)
         return hi;
      return 32'(v);
   endfunction

   // Mostly back-to-back, sometimes a short gap, now and then a long one.
   function automatic int pick_gap(input bit quiet);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (quiet || roll < 65)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Mostly small sizes, odd ones included; rarely below range, above
   // range or exactly at the top.
   function automatic logic [SW-1:0] pick_size(input int unsigned typical_max);
      int unsigned roll;
      roll = $urandom_range(19, 0);
      if (roll == 0)
         return SW'($urandom_range(1, 0));
      if (roll == 1)
         return SW'($urandom_range(8191, FRAME_MAX + 1));
      if (roll == 2)
         return SW'(FRAME_MAX);
      return SW'($urandom_range(typical_max, 2));
   endfunction

   // Behavioral 2x2 binner: advance the counters for one pixel and return
   // the binned pixel when this pixel closes a block.
   task automatic bin_pixel(input pbav_pkg::req_payload_type item, output bit produced,
                            output pbav_pkg::rsp_payload_type result);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned used_w;
      int unsigned used_h;
      int unsigned idx;
      int unsigned block_sum;
      w = size_limit(frame_width_reg, FRAME_MAX);
      h = size_limit(frame_height_reg, pbav_pkg::MAX_HEIGHT);
      produced = 1'b0;
      result = '0;

      // Frame start pins the pixel to the top-left corner.
      if (item.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      // Counters left beyond a shrunken size wrap before the pixel is used.
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h)
         row_pos = 0;

      c = col_pos;
      r = row_pos;
      used_w = w & ~32'd1;
      used_h = h & ~32'd1;
      idx = c >> 1;

      // Odd last column and odd last row never join a block.
      if (r < used_h && c < used_w) begin
         if ((c & 1) == 0) begin
            left_px = item.pixel_value;
         end else if ((r & 1) == 0) begin
            pair_sum_store[idx] = left_px + item.pixel_value;
            pair_sum_valid[idx] = 1'b1;
         end else begin
            if (!pair_sum_valid[idx])
               flag_mismatch($sformatf("stimulus reached unwritten line entry %0d", idx));
            block_sum = pair_sum_store[idx] + left_px + item.pixel_value;
            result.binned_value = 16'((block_sum + 2) >> 2);
            result.frame_last = (r == used_h - 1) && (c == used_w - 1);
            produced = 1'b1;
         end
      end

      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h)
            row_pos = 0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offer one pixel and hold it until the core takes it. Valid stays high
   // on return so a back-to-back pixel needs no second assignment.
   task automatic send_pixel(input logic [15:0] value, input logic fs, input bit pin,
                             input pbav_pkg::rsp_payload_type pinned);
      req_if.valid   <= 1'b1;
      req_if.payload <= '{pixel_value: value, frame_start: fs};
      pinned_check   <= pin;
      pinned_result  <= pinned;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   task automatic pause_sender();
      int gap;
      gap = pick_gap(sender_quiet);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid first; then wait until every predicted pixel came back and
   // let the pipeline drain pixels that close no block.
   task automatic wait_for_idle();
      while (binned_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pbav_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [SW-1:0] value);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= '{reg_index: index, wr_data: value};
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stream a run of pixels; open_frame marks the first one as a frame
   // start, with_noise scatters stray frame starts that restart the frame.
   task automatic stream_pixels(input int count, input bit open_frame, input bit with_noise);
      logic        fs;
      logic [15:0] value;
      for (int i = 0; i < count; i++) begin
         fs = (i == 0 && open_frame) || (with_noise && $urandom_range(49, 0) == 0);
         case ($urandom_range(9, 0))
            0: value = 16'h0000;
            1: value = 16'hFFFF;
            default: value = 16'($urandom);
         endcase
         send_pixel(value, fs, 1'b0, '0);
         pause_sender();
      end
      req_if.valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Response sink: random ready with runs and gaps; one long hold-off when
   // the stimulus asks for it, to fill the output queue and stall the input.
   // -------------------------------------------------------------------------
   initial begin
      int run_left;
      int stall_left;
      run_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            run_left = 0;
            stall_left = LONG_HOLD;
         end else if (run_left == 0 && stall_left == 0) begin
            run_left = $urandom_range(40, 1);
            stall_left = pick_gap(sink_quiet);
         end
         if (run_left > 0) begin
            rsp_if.ready <= 1'b1;
            run_left--;
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: track register writes, predict on every accepted pixel, check
   // every accepted response against the oldest prediction, and watch for a
   // hang. Everything is sampled on the edge, before the edge's updates land.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      bit                        moved;
      bit                        produced;
      pbav_pkg::rsp_payload_type predicted;
      pbav_pkg::rsp_payload_type oldest;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_if.valid && csr_if.ready) begin
            moved = 1'b1;
            case (csr_if.payload.reg_index)
               pbav_pkg::CSR_FRAME_WIDTH:  frame_width_reg = csr_if.payload.wr_data;
               pbav_pkg::CSR_FRAME_HEIGHT: frame_height_reg = csr_if.payload.wr_data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            bin_pixel(req_if.payload, produced, predicted);
            if (produced)
               binned_expect_q.push_back(pinned_check ? pinned_result : predicted);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (binned_expect_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected binned pixel %h last %b",
                                       rsp_if.payload.binned_value,
                                       rsp_if.payload.frame_last));
            end else begin
               oldest = binned_expect_q.pop_front();
               if (rsp_if.payload.binned_value !== oldest.binned_value)
                  flag_mismatch($sformatf("binned_value got %h want %h",
                                          rsp_if.payload.binned_value,
                                          oldest.binned_value));
               if (rsp_if.payload.frame_last !== oldest.frame_last)
                  flag_mismatch($sformatf("frame_last got %b want %b",
                                          rsp_if.payload.frame_last,
                                          oldest.frame_last));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("pixel_binning_2x2_average_core_tb: FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [SW-1:0]         new_width;
      logic [SW-1:0]         new_height;
      int                    random_done;
      int                    phase;
      int                    run_len;

      // Known values on every input from time zero.
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      rsp_if.ready = 1'b0;
      pinned_check = 1'b0;
      pinned_result = '0;

      frame_width_reg = SW'(pbav_pkg::SIZE_RESET);
      frame_height_reg = SW'(pbav_pkg::SIZE_RESET);
      left_px = '0;
      col_pos = 0;
      row_pos = 0;
      foreach (pair_sum_valid[i])
         pair_sum_valid[i] = 1'b0;
      fail_count = 0;
      idle_cycles = 0;
      sender_quiet = 1'b0;
      sink_quiet = 1'b0;
      hold_off_request = 1'b0;

      directed_rows = '{
         // Sizes below range act as 2 x 2.
         '{ROW_WIDTH,  16'd1,    1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_HEIGHT, 16'd0,    1'b0, 1'b0, 16'h0000, 1'b0},
         // Near full scale: mean rounds back up to full scale.
         '{ROW_PIXEL,  16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'hFFFE, 1'b0, 1'b1, 16'hFFFF, 1'b1},
         // Next frame by wrap alone; a sum of 2 rounds half up to 1.
         '{ROW_PIXEL,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h0001, 1'b0, 1'b1, 16'h0001, 1'b1},
         // Odd sizes: last column and last row fall out of every block.
         '{ROW_WIDTH,  16'd3,    1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_HEIGHT, 16'd3,    1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'hAAAA, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h5555, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h5555, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h5555, 1'b0, 1'b0, 16'h0000, 1'b0},
         // Shrink the width mid row: column 6 wraps into row 1.
         '{ROW_WIDTH,  16'd8,    1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_HEIGHT, 16'd4,    1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h0F0F, 1'b1, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'hF0F0, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h0003, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h8001, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h4321, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'hC0DE, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_WIDTH,  16'd4,    1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h7FFE, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h0002, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
         '{ROW_PIXEL,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
         // Shrink the height (below range, acts as 2): row 2 wraps to row 0
         // as the random part carries on without a frame start.
         '{ROW_HEIGHT, 16'd1,    1'b0, 1'b0, 16'h0000, 1'b0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed sequence. Register lines wait for an idle core.
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_PIXEL: begin
               send_pixel(directed_rows[i].value, directed_rows[i].fs, directed_rows[i].pin,
                          '{binned_value: directed_rows[i].want,
                            frame_last: directed_rows[i].want_last});
               pause_sender();
            end
            ROW_WIDTH: begin
               req_if.valid <= 1'b0;
               wait_for_idle();
               write_reg(pbav_pkg::CSR_FRAME_WIDTH, directed_rows[i].value[SW-1:0]);
            end
            ROW_HEIGHT: begin
               req_if.valid <= 1'b0;
               wait_for_idle();
               write_reg(pbav_pkg::CSR_FRAME_HEIGHT, directed_rows[i].value[SW-1:0]);
            end
            default: ;
         endcase
      end
      req_if.valid <= 1'b0;

      // Random frames. Phase 0 keeps the directed sizes and counters; every
      // later phase drains, picks new sizes and opens a fresh frame.
      random_done = 0;
      phase = 0;
      while (random_done < RANDOM_ITEMS) begin
         if (phase > 0) begin
            wait_for_idle();
            new_width = pick_size(14);
            new_height = pick_size(10);
            write_reg(pbav_pkg::CSR_FRAME_WIDTH, new_width);
            write_reg(pbav_pkg::CSR_FRAME_HEIGHT, new_height);
         end
         // Every sixth phase runs flat out on both sides.
         sender_quiet = (phase % 6 == 5);
         sink_quiet = (phase % 6 == 5);
         run_len = $urandom_range(90, 30);
         if (phase == 3) begin
            // Back-pressure: hold the sink off while the sender keeps
            // offering, so the output queue fills and the input stalls.
            sender_quiet = 1'b1;
            run_len = 90;
            hold_off_request = 1'b1;
         end
         stream_pixels(run_len, phase > 0, 1'b1);
         random_done += run_len;
         phase++;
      end
      sender_quiet = 1'b0;
      sink_quiet = 1'b0;

      // Drain, then give stray responses a few cycles to show up.
      while (binned_expect_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("pixel_binning_2x2_average_core_tb: PASS");
      end else begin
         $display("pixel_binning_2x2_average_core_tb: FAIL");
      end
      $finish;
   end

endmodule
